// ===== rtl/npq_pkg.sv =====
// ----------------------------------------------------------------------------
// npq_pkg - shared definitions for the nearest palette colour quantiser
// Widths, the fixed palette ROM and the default palette size.
// ----------------------------------------------------------------------------
package npq_pkg;

    localparam int PIX_W            = 24;
    localparam int CHAN_W           = 8;
    localparam int IDX_W            = 5;
    // Sum of three squared 8-bit differences is at most 195075.
    localparam int DIST_W           = 18;
    localparam int ROM_ENTRIES      = 30;
    localparam int PALETTE_SIZE_DEF = 30;

    // Fixed palette ROM, packed as red 23:16, green 15:8, blue 7:0.
    function automatic logic [PIX_W-1:0] palette_color(input logic [IDX_W-1:0] idx);
        logic [PIX_W-1:0] color;
        unique case (idx)
            5'd0:    color = 24'hC0392B;
            5'd1:    color = 24'h922B21;
            5'd2:    color = 24'h641E16;
            5'd3:    color = 24'h9B59B6;
            5'd4:    color = 24'h6C3483;
            5'd5:    color = 24'h4A235A;
            5'd6:    color = 24'h3498DB;
            5'd7:    color = 24'h2874A6;
            5'd8:    color = 24'h1B4F72;
            5'd9:    color = 24'h16A085;
            5'd10:   color = 24'h117A65;
            5'd11:   color = 24'h0E6251;
            5'd12:   color = 24'h2ECC71;
            5'd13:   color = 24'h239B56;
            5'd14:   color = 24'h186A3B;
            5'd15:   color = 24'hF1C40F;
            5'd16:   color = 24'hB7950B;
            5'd17:   color = 24'h7D6608;
            5'd18:   color = 24'hF39C12;
            5'd19:   color = 24'hB9770E;
            5'd20:   color = 24'h7E5109;
            5'd21:   color = 24'hD35400;
            5'd22:   color = 24'hA04000;
            5'd23:   color = 24'h6E2C00;
            5'd24:   color = 24'hECF0F1;
            5'd25:   color = 24'hB3B6B7;
            5'd26:   color = 24'h7B7D7D;
            5'd27:   color = 24'h95A5A6;
            5'd28:   color = 24'h717D7E;
            5'd29:   color = 24'h4D5656;
            default: color = '0;
        endcase
        return color;
    endfunction

endpackage

// ===== rtl/npq_dist.sv =====
// ----------------------------------------------------------------------------
// npq_dist - squared RGB distance to every searched palette entry
// One squarer per channel and entry, all working in parallel.
// ----------------------------------------------------------------------------
module npq_dist #(
    parameter int SEARCH_N = npq_pkg::PALETTE_SIZE_DEF
) (
    input  logic [npq_pkg::PIX_W-1:0]                  pixel,
    output logic [SEARCH_N-1:0][npq_pkg::DIST_W-1:0]   dist_sq
);

    localparam int CW = npq_pkg::CHAN_W;

    for (genvar i = 0; i < SEARCH_N; i++) begin : g_entry
        logic [npq_pkg::PIX_W-1:0] ref_color;
        logic [CW-1:0]             diff [3];
        logic [2*CW-1:0]           sq   [3];

        assign ref_color = npq_pkg::palette_color(npq_pkg::IDX_W'(i));

        for (genvar c = 0; c < 3; c++) begin : g_chan
            logic [CW-1:0] a;
            logic [CW-1:0] b;
            assign a       = pixel[c*CW +: CW];
            assign b       = ref_color[c*CW +: CW];
            assign diff[c] = (a >= b) ? (a - b) : (b - a);
            assign sq[c]   = diff[c] * diff[c];
        end

        assign dist_sq[i] = npq_pkg::DIST_W'(sq[0]) + npq_pkg::DIST_W'(sq[1])
                          + npq_pkg::DIST_W'(sq[2]);
    end

endmodule

// ===== rtl/npq_min_tree.sv =====
// ----------------------------------------------------------------------------
// npq_min_tree - index of the smallest distance, lowest index on ties
// Balanced compare-select tree; the left operand always covers lower indices.
// ----------------------------------------------------------------------------
module npq_min_tree #(
    parameter int SEARCH_N = npq_pkg::PALETTE_SIZE_DEF
) (
    input  logic [SEARCH_N-1:0][npq_pkg::DIST_W-1:0] dist_sq,
    output logic [npq_pkg::IDX_W-1:0]                best_idx
);

    localparam int LEVELS = (SEARCH_N > 1) ? $clog2(SEARCH_N) : 0;
    localparam int PAD    = 1 << LEVELS;

    logic [npq_pkg::DIST_W-1:0] node_d [LEVELS+1][PAD];
    logic [npq_pkg::IDX_W-1:0]  node_i [LEVELS+1][PAD];

    always_comb
    begin
        // Padding leaves carry the largest code, which no real distance reaches.
        for (int lv = 0; lv <= LEVELS; lv++)
        begin
            for (int j = 0; j < PAD; j++)
            begin
                node_d[lv][j] = '1;
                node_i[lv][j] = '0;
            end
        end
        for (int j = 0; j < SEARCH_N; j++)
        begin
            node_d[0][j] = dist_sq[j];
            node_i[0][j] = npq_pkg::IDX_W'(j);
        end
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            for (int j = 0; j < (PAD >> (lv + 1)); j++)
            begin
                // The right entry wins only when strictly nearer.
                if (node_d[lv][2*j+1] < node_d[lv][2*j])
                begin
                    node_d[lv+1][j] = node_d[lv][2*j+1];
                    node_i[lv+1][j] = node_i[lv][2*j+1];
                end
                else
                begin
                    node_d[lv+1][j] = node_d[lv][2*j];
                    node_i[lv+1][j] = node_i[lv][2*j];
                end
            end
        end
    end

    assign best_idx = node_i[LEVELS][0];

endmodule

// ===== rtl/nearest_palette_color_quantizer_top.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_quantizer_top - maps a pixel to its nearest palette colour
// Three-stage pipeline: input register, distance register, result register.
// ----------------------------------------------------------------------------
// Usage
//   The pixel channel (pixel_valid, pixel_ready, pixel_color) carries one
//   packed 24-bit RGB pixel per request. The result channel (result_valid,
//   result_ready, quantized_color, palette_index) returns one request per
//   pixel: the nearest palette colour by squared Euclidean distance and its
//   index, the lowest index winning when distances are equal.
//   The pixel is registered, all palette distances are computed in parallel
//   and registered, and the minimum search tree feeds the result register.
//   Throughput is one pixel per cycle while the receiver takes results;
//   each pipeline stage has its own valid flag and loads whenever it is
//   empty or its successor is taking its contents, so bubbles are squeezed
//   out while the receiver stalls.
//   When result_ready is low with a result waiting, the result is held
//   unchanged and the stages behind it keep filling; pixel_ready falls only
//   once all three stages hold pixels.
//   Asynchronous reset empties every stage; no result is shown until a new
//   pixel has passed through. The palette is a fixed ROM, so no
//   configuration or clearing is needed after reset.
// ----------------------------------------------------------------------------
module nearest_palette_color_quantizer_top #(
    parameter int PALETTE_SIZE = npq_pkg::PALETTE_SIZE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pixel_valid,
    output logic                         pixel_ready,
    input  logic [npq_pkg::PIX_W-1:0]    pixel_color,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [npq_pkg::PIX_W-1:0]    quantized_color,
    output logic [npq_pkg::IDX_W-1:0]    palette_index
);

    // Only the entries held in the ROM can be searched.
    localparam int SEARCH_N = (PALETTE_SIZE < npq_pkg::ROM_ENTRIES) ?
                              PALETTE_SIZE : npq_pkg::ROM_ENTRIES;

    // Stage valid flags.
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;

    // Stage payloads.
    logic [npq_pkg::PIX_W-1:0]                s1_pixel_reg;
    logic [SEARCH_N-1:0][npq_pkg::DIST_W-1:0] s2_dist_reg;
    logic [SEARCH_N-1:0][npq_pkg::DIST_W-1:0] s2_dist_next;
    logic [npq_pkg::IDX_W-1:0]                s3_idx_reg;
    logic [npq_pkg::IDX_W-1:0]                s3_idx_next;

    // A stage may load when it is empty or its contents move on this cycle.
    logic s1_ready, s2_ready, s3_ready;

    assign s3_ready = !s3_valid_reg || result_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign s1_valid_next = s1_ready ? pixel_valid  : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;

    npq_dist #(
        .SEARCH_N (SEARCH_N)
    ) u_dist (
        .pixel   (s1_pixel_reg),
        .dist_sq (s2_dist_next)
    );

    npq_min_tree #(
        .SEARCH_N (SEARCH_N)
    ) u_min_tree (
        .dist_sq  (s2_dist_reg),
        .best_idx (s3_idx_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // Payload registers follow their stage's load enable and need no reset.
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_pixel_reg <= pixel_color;
        end
        if (s2_ready)
        begin
            s2_dist_reg <= s2_dist_next;
        end
        if (s3_ready)
        begin
            s3_idx_reg <= s3_idx_next;
        end
    end

    assign pixel_ready     = s1_ready;
    assign result_valid    = s3_valid_reg;
    assign palette_index   = s3_idx_reg;
    // The colour is read from the ROM at the registered index.
    assign quantized_color = npq_pkg::palette_color(s3_idx_reg);

endmodule

// ===== rtl/npq_checker.sv =====
// ----------------------------------------------------------------------------
// npq_checker - port-level checks for the palette quantiser
// Watches the top-level ports only and is attached by a bind statement.
// ----------------------------------------------------------------------------
module npq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         pixel_valid,
    input logic                         pixel_ready,
    input logic [npq_pkg::PIX_W-1:0]    pixel_color,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [npq_pkg::PIX_W-1:0]    quantized_color,
    input logic [npq_pkg::IDX_W-1:0]    palette_index
);

    // A stalled result must hold still.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(palette_index) && $stable(quantized_color))
        else $error("result changed while stalled");

    // With the receiver taking results, every stage can advance.
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> pixel_ready)
        else $error("pixel_ready low while result_ready high");

    // The index always names an entry of the ROM.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (palette_index < npq_pkg::IDX_W'(npq_pkg::ROM_ENTRIES)))
        else $error("palette index beyond the ROM");

    // The returned colour is the palette entry at the returned index.
    a_color_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (quantized_color == npq_pkg::palette_color(palette_index)))
        else $error("colour does not match the palette index");

endmodule

bind nearest_palette_color_quantizer_top npq_checker u_npq_checker (.*);
